>>> rtl/core/msw_pkg.sv
package msw_pkg;

    localparam int SUM_WIDTH   = 40;
    localparam int COUNT_WIDTH = 24;

    localparam int NUM_CH     = 6;
    localparam int TOTAL_W    = 48;
    localparam int WIN_W      = 40;
    localparam int ANG_W      = 56;
    localparam int AVG_W      = 16;
    localparam int RATE_SHIFT = 15;
    localparam int QUO_W      = ANG_W + RATE_SHIFT;
    localparam int DVS_W      = WIN_W;
    localparam int STEP_W     = $clog2(QUO_W);
    localparam int OP_W       = 3;
    localparam int CH_SEL_W   = 7;

    localparam logic [OP_W-1:0] OP_ANGLE = 3'd0;
    localparam logic [OP_W-1:0] OP_LAST  = 3'd6;

    localparam logic [2:0] MODE_RECORD = 3'd0;
    localparam logic [2:0] MODE_MAX    = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_OPSEL,
        S_DIV,
        S_STORE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic            accept;
        logic            div_start;
        logic            div_step;
        logic            div_store;
        logic            emit;
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic window_due;
        logic op_empty;
        logic div_done;
        logic out_free;
    } t_sts;

    // Window close threshold in ticks for periods 0.1, 1, 10 and 100 s.
    function automatic logic signed [WIN_W-1:0] window_limit(input logic [2:0] mode);
        logic signed [WIN_W-1:0] lim;
        unique case (mode)
            3'd1:    lim = WIN_W'(3276);
            3'd2:    lim = WIN_W'(32768);
            3'd3:    lim = WIN_W'(327680);
            3'd4:    lim = WIN_W'(3276800);
            default: lim = '0;
        endcase
        return lim;
    endfunction

endpackage

>>> rtl/core/msw_ctrl.sv
module msw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  msw_pkg::t_sts   i_sts,
    output msw_pkg::t_cmd   o_cmd
);

    msw_pkg::t_state r_state, n_state;
    logic [msw_pkg::OP_W-1:0] r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msw_pkg::S_IDLE;
            r_op    <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            msw_pkg::S_IDLE: begin
                if (i_valid) n_state = msw_pkg::S_CHECK;
            end
            msw_pkg::S_CHECK: begin
                n_op    = msw_pkg::OP_ANGLE;
                n_state = i_sts.window_due ? msw_pkg::S_OPSEL : msw_pkg::S_IDLE;
            end
            msw_pkg::S_OPSEL: begin
                if (!i_sts.op_empty) begin
                    n_state = msw_pkg::S_DIV;
                end else if (r_op == msw_pkg::OP_LAST) begin
                    n_state = msw_pkg::S_EMIT;
                end else begin
                    n_op = r_op + 1'b1;
                end
            end
            msw_pkg::S_DIV: begin
                if (i_sts.div_done) n_state = msw_pkg::S_STORE;
            end
            msw_pkg::S_STORE: begin
                if (r_op == msw_pkg::OP_LAST) begin
                    n_state = msw_pkg::S_EMIT;
                end else begin
                    n_op    = r_op + 1'b1;
                    n_state = msw_pkg::S_OPSEL;
                end
            end
            msw_pkg::S_EMIT: begin
                if (i_sts.out_free) n_state = msw_pkg::S_IDLE;
            end
            default: n_state = msw_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = r_op;
        o_stall         = 1'b1;
        unique case (r_state)
            msw_pkg::S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            msw_pkg::S_OPSEL: o_cmd.div_start = !i_sts.op_empty;
            msw_pkg::S_DIV:   o_cmd.div_step  = 1'b1;
            msw_pkg::S_STORE: o_cmd.div_store = 1'b1;
            msw_pkg::S_EMIT:  o_cmd.emit      = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

>>> rtl/core/msw_dp.sv
module msw_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  msw_pkg::t_cmd                       i_cmd,
    output msw_pkg::t_sts                       o_sts,
    input  logic                                i_cfg_valid,
    input  logic [2:0]                          i_averaging_period,
    input  logic signed [31:0]                  i_angle_increment,
    input  logic [15:0]                         i_channel_word,
    input  logic signed [15:0]                  i_sample_value,
    input  logic signed [15:0]                  i_time_increment,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic signed [msw_pkg::TOTAL_W-1:0]  o_elapsed_ticks,
    output logic signed [msw_pkg::ANG_W-1:0]    o_angle_value,
    output logic [15:0]                         o_avg_temp_one,
    output logic [15:0]                         o_avg_temp_two,
    output logic signed [15:0]                  o_avg_current_one,
    output logic signed [15:0]                  o_avg_current_two,
    output logic signed [15:0]                  o_avg_voltage,
    output logic signed [15:0]                  o_avg_amplitude,
    output logic [msw_pkg::NUM_CH-1:0]          o_present_mask
);

    localparam int SW = msw_pkg::SUM_WIDTH;
    localparam int CW = msw_pkg::COUNT_WIDTH;
    localparam int WW = msw_pkg::WIN_W;
    localparam int AW = msw_pkg::ANG_W;
    localparam int QW = msw_pkg::QUO_W;
    localparam int DW = msw_pkg::DVS_W;
    localparam int NC = msw_pkg::NUM_CH;

    logic [2:0]                     r_period;
    logic [msw_pkg::TOTAL_W-1:0]    r_total;
    logic signed [WW-1:0]           r_win;
    logic signed [AW-1:0]           r_ang;
    logic signed [SW-1:0]           r_sum [NC];
    logic [CW-1:0]                  r_cnt [NC];
    logic [msw_pkg::AVG_W-1:0]      r_avg [NC];
    logic signed [AW-1:0]           r_rate;

    logic [QW-1:0]                  r_quo;
    logic [DW-1:0]                  r_rem;
    logic [DW-1:0]                  r_dvs;
    logic                           r_neg;
    logic [msw_pkg::STEP_W-1:0]     r_step;
    logic                           r_out_valid;

    // Accumulation arithmetic.
    logic signed [WW:0]             win_sum;
    logic signed [WW-1:0]           win_sat;
    logic signed [AW:0]             ang_sum;
    logic signed [AW-1:0]           ang_sat;
    logic [msw_pkg::CH_SEL_W-1:0]   ch;
    logic signed [16:0]             sample;
    logic signed [SW:0]             ch_sum [NC];
    logic signed [SW-1:0]           ch_sat [NC];

    logic [2:0]                     mode;
    logic [NC-1:0]                  present;

    // Division setup and step.
    logic signed [SW-1:0]           op_sum;
    logic [CW-1:0]                  op_cnt;
    logic [SW-1:0]                  sum_mag;
    logic [AW-1:0]                  ang_mag;
    logic [DW:0]                    rem_sh;
    logic                           q_bit;
    logic [QW-1:0]                  rate_lim;
    logic [QW-1:0]                  rate_mag;
    logic [msw_pkg::AVG_W-1:0]      avg_val;

    always_comb begin
        mode = (r_period > msw_pkg::MODE_MAX) ? msw_pkg::MODE_MAX : r_period;
        win_sum = {r_win[WW-1], r_win} + (WW+1)'(i_time_increment);
        if (win_sum[WW] != win_sum[WW-1]) begin
            win_sat = win_sum[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
        end else begin
            win_sat = win_sum[WW-1:0];
        end
        ang_sum = {r_ang[AW-1], r_ang} + (AW+1)'(i_angle_increment);
        if (ang_sum[AW] != ang_sum[AW-1]) begin
            ang_sat = ang_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end else begin
            ang_sat = ang_sum[AW-1:0];
        end
        ch = i_channel_word[msw_pkg::CH_SEL_W-1:0];
        sample = (ch < msw_pkg::CH_SEL_W'(2)) ? $signed({1'b0, i_sample_value})
                                              : 17'(i_sample_value);
        for (int i = 0; i < NC; i++) begin
            ch_sum[i] = {r_sum[i][SW-1], r_sum[i]} + (SW+1)'(sample);
            if (ch_sum[i][SW] != ch_sum[i][SW-1]) begin
                ch_sat[i] = ch_sum[i][SW] ? {1'b1, {(SW-1){1'b0}}}
                                          : {1'b0, {(SW-1){1'b1}}};
            end else begin
                ch_sat[i] = ch_sum[i][SW-1:0];
            end
            present[i] = (r_cnt[i] != '0);
        end
    end

    always_comb begin
        op_sum = '0;
        op_cnt = '0;
        for (int i = 0; i < NC; i++) begin
            if (i_cmd.op == msw_pkg::OP_W'(i + 1)) begin
                op_sum = r_sum[i];
                op_cnt = r_cnt[i];
            end
        end
        sum_mag = op_sum[SW-1] ? SW'(-op_sum) : SW'(op_sum);
        ang_mag = r_ang[AW-1] ? AW'(-r_ang) : AW'(r_ang);
        rem_sh  = {r_rem, r_quo[QW-1]};
        q_bit   = (rem_sh >= {1'b0, r_dvs});
        rate_lim = r_neg ? (QW'(1) << (AW - 1)) : ((QW'(1) << (AW - 1)) - QW'(1));
        rate_mag = (r_quo > rate_lim) ? rate_lim : r_quo;
        avg_val  = r_neg ? msw_pkg::AVG_W'(-r_quo[msw_pkg::AVG_W-1:0])
                         : r_quo[msw_pkg::AVG_W-1:0];

        o_sts.window_due = (mode == msw_pkg::MODE_RECORD) ||
                           (r_win > msw_pkg::window_limit(mode));
        o_sts.op_empty   = (i_cmd.op == msw_pkg::OP_ANGLE) ? (mode == msw_pkg::MODE_RECORD)
                                                           : (op_cnt == '0);
        o_sts.div_done   = (r_step == msw_pkg::STEP_W'(QW - 1));
        o_sts.out_free   = !r_out_valid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= '0;
            r_total     <= '0;
            r_win       <= '0;
            r_ang       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NC; i++) begin
                r_sum[i] <= '0;
                r_cnt[i] <= '0;
                r_avg[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) r_period <= i_averaging_period;
            if (i_cmd.accept) begin
                r_total <= r_total + msw_pkg::TOTAL_W'(i_time_increment);
                r_win   <= win_sat;
                r_ang   <= ang_sat;
                for (int i = 0; i < NC; i++) begin
                    if (ch == msw_pkg::CH_SEL_W'(i) && r_cnt[i] != {CW{1'b1}}) begin
                        r_sum[i] <= ch_sat[i];
                        r_cnt[i] <= r_cnt[i] + 1'b1;
                    end
                end
            end
            if (i_cmd.div_store && i_cmd.op != msw_pkg::OP_ANGLE) begin
                for (int i = 0; i < NC; i++) begin
                    if (i_cmd.op == msw_pkg::OP_W'(i + 1)) r_avg[i] <= avg_val;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_win       <= '0;
                r_ang       <= '0;
                for (int i = 0; i < NC; i++) begin
                    r_sum[i] <= '0;
                    r_cnt[i] <= '0;
                    // Temperatures hold their last average; the others read 0 when empty.
                    if (i >= 2) r_avg[i] <= '0;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Shared restoring divider, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_step <= '0;
            if (i_cmd.op == msw_pkg::OP_ANGLE) begin
                r_quo <= {ang_mag, {msw_pkg::RATE_SHIFT{1'b0}}};
                r_dvs <= DW'(r_win);
                r_neg <= r_ang[AW-1];
            end else begin
                r_quo <= QW'(sum_mag);
                r_dvs <= DW'(op_cnt);
                r_neg <= op_sum[SW-1];
            end
        end else if (i_cmd.div_step) begin
            r_rem  <= q_bit ? DW'(rem_sh - {1'b0, r_dvs}) : rem_sh[DW-1:0];
            r_quo  <= {r_quo[QW-2:0], q_bit};
            r_step <= r_step + 1'b1;
        end
        if (i_cmd.div_store && i_cmd.op == msw_pkg::OP_ANGLE) begin
            r_rate <= r_neg ? AW'(-rate_mag) : AW'(rate_mag);
        end
        if (i_cmd.emit) begin
            o_elapsed_ticks   <= r_total;
            o_angle_value     <= (mode == msw_pkg::MODE_RECORD) ? r_ang : r_rate;
            o_avg_temp_one    <= r_avg[0];
            o_avg_temp_two    <= r_avg[1];
            o_avg_current_one <= r_avg[2];
            o_avg_current_two <= r_avg[3];
            o_avg_voltage     <= r_avg[4];
            o_avg_amplitude   <= r_avg[5];
            o_present_mask    <= present;
        end
    end

    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_win == '0) && (r_ang == '0))
        else $error("window not cleared after emit");
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.emit))
        else $error("result appeared without emit");
    a_no_empty_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !o_sts.op_empty)
        else $error("division started for empty operand");
    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_dvs != '0))
        else $error("division by zero");
`endif

endmodule

>>> rtl/core/multiplexed_sensor_window_averager.sv
// An item that closes no window is accepted and checked, then the block is idle again; one
// that closes a window reaches the output register through a quotient (set-up, 71 divider
// steps, store) for the angle rate and each non-empty channel; empty ones are skipped.
// One item at a time: the next item is taken once the result is in the output
// register, which may still be waiting for the consumer.
// Reset (synchronous, active low) clears all sums, counts, held temperatures and the period.
module multiplexed_sensor_window_averager (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [31:0]                  i_angle_increment,
    input  logic [15:0]                         i_channel_word,
    input  logic signed [15:0]                  i_sample_value,
    input  logic signed [15:0]                  i_time_increment,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [2:0]                          i_averaging_period,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [msw_pkg::TOTAL_W-1:0]  o_elapsed_ticks,
    output logic signed [msw_pkg::ANG_W-1:0]    o_angle_value,
    output logic [15:0]                         o_avg_temp_one,
    output logic [15:0]                         o_avg_temp_two,
    output logic signed [15:0]                  o_avg_current_one,
    output logic signed [15:0]                  o_avg_current_two,
    output logic signed [15:0]                  o_avg_voltage,
    output logic signed [15:0]                  o_avg_amplitude,
    output logic [msw_pkg::NUM_CH-1:0]          o_present_mask
);

    // The controller sequences accumulation, the window check and the divisions.
    msw_pkg::t_cmd cmd;
    msw_pkg::t_sts sts;

    // The period register is always writable; the user must write it only while idle.
    assign o_cfg_ready = 1'b1;

    msw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The datapath holds the window state, the shared divider and the output register.
    msw_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_valid        (i_cfg_valid),
        .i_averaging_period (i_averaging_period),
        .i_angle_increment  (i_angle_increment),
        .i_channel_word     (i_channel_word),
        .i_sample_value     (i_sample_value),
        .i_time_increment   (i_time_increment),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_elapsed_ticks    (o_elapsed_ticks),
        .o_angle_value      (o_angle_value),
        .o_avg_temp_one     (o_avg_temp_one),
        .o_avg_temp_two     (o_avg_temp_two),
        .o_avg_current_one  (o_avg_current_one),
        .o_avg_current_two  (o_avg_current_two),
        .o_avg_voltage      (o_avg_voltage),
        .o_avg_amplitude    (o_avg_amplitude),
        .o_present_mask     (o_present_mask)
    );

endmodule

>>> verif/tb_multiplexed_sensor_window_averager.sv
`timescale 1ns / 100ps

module tb_multiplexed_sensor_window_averager;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int IDLE_SETTLE    = 20;
    localparam int LONG_HOLD      = 400;

    // Window close thresholds in ticks, indexed by the effective period.
    localparam longint WINDOW_TICKS [0:4] = '{0, 3276, 32768, 327680, 3276800};

    // One expected or observed output item.
    typedef struct packed {
        logic signed [msw_pkg::TOTAL_W-1:0] elapsed;
        logic signed [msw_pkg::ANG_W-1:0]   angle;
        logic [msw_pkg::NUM_CH-1:0][15:0]   avg;
        logic [msw_pkg::NUM_CH-1:0]         mask;
    } t_window_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic signed [31:0]                  i_angle_increment = '0;
    logic [15:0]                         i_channel_word = '0;
    logic signed [15:0]                  i_sample_value = '0;
    logic signed [15:0]                  i_time_increment = '0;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [2:0]                          i_averaging_period = '0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic signed [msw_pkg::TOTAL_W-1:0]  o_elapsed_ticks;
    logic signed [msw_pkg::ANG_W-1:0]    o_angle_value;
    logic [15:0]                         o_avg_temp_one;
    logic [15:0]                         o_avg_temp_two;
    logic signed [15:0]                  o_avg_current_one;
    logic signed [15:0]                  o_avg_current_two;
    logic signed [15:0]                  o_avg_voltage;
    logic signed [15:0]                  o_avg_amplitude;
    logic [msw_pkg::NUM_CH-1:0]          o_present_mask;

    multiplexed_sensor_window_averager i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_angle_increment  (i_angle_increment),
        .i_channel_word     (i_channel_word),
        .i_sample_value     (i_sample_value),
        .i_time_increment   (i_time_increment),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_averaging_period (i_averaging_period),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_elapsed_ticks    (o_elapsed_ticks),
        .o_angle_value      (o_angle_value),
        .o_avg_temp_one     (o_avg_temp_one),
        .o_avg_temp_two     (o_avg_temp_two),
        .o_avg_current_one  (o_avg_current_one),
        .o_avg_current_two  (o_avg_current_two),
        .o_avg_voltage      (o_avg_voltage),
        .o_avg_amplitude    (o_avg_amplitude),
        .o_present_mask     (o_present_mask)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the block's state, kept in step with every accepted record.
    longint unsigned  total_ticks;
    longint           win_ticks;
    longint           win_angle;
    longint           chan_sum [msw_pkg::NUM_CH];
    longint unsigned  chan_count [msw_pkg::NUM_CH];
    logic [15:0]      held_temp [2];
    logic [2:0]       period_reg;

    t_window_result   pending_windows [$];

    int               error_count = 0;
    int               records_sent = 0;
    int               windows_seen = 0;
    int               idle_cycles = 0;

    // Sender pacing: bursts of random length separated by random gaps.
    int               burst_left = 0;
    bit               pacing_on = 1'b0;

    // Receiver behaviour: 0 never stalls, 1 random, 2 periodic pattern.
    int               stall_style = 0;
    int               hold_requests = 0;
    int               hold_seen = 0;
    int               hold_left = 0;
    int               stall_phase = 0;

    function automatic longint sat_add(longint a, longint b, int w);
        longint hi;
        longint lo;
        longint s;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        s  = a + b;
        if (s > hi) return hi;
        if (s < lo) return lo;
        return s;
    endfunction

    function automatic void clear_window_sums();
        win_ticks = 0;
        win_angle = 0;
        for (int i = 0; i < msw_pkg::NUM_CH; i++) begin
            chan_sum[i]   = 0;
            chan_count[i] = 0;
        end
    endfunction

    // Accumulates one record and, where a window closes, builds the result.
    function automatic bit accumulate_record(input logic signed [31:0] ang,
                                             input logic [15:0] cw,
                                             input logic signed [15:0] sv,
                                             input logic signed [15:0] dt,
                                             output t_window_result res);
        longint          sample;
        longint          mag_angle;
        longint unsigned t;
        longint unsigned q;
        longint unsigned r;
        longint unsigned rate;
        longint          angle_out;
        longint unsigned mag;
        int              ch;
        int              mode;
        res        = '0;
        ch         = int'(cw[msw_pkg::CH_SEL_W-1:0]);
        mode       = (period_reg > msw_pkg::MODE_MAX) ? int'(msw_pkg::MODE_MAX)
                                                      : int'(period_reg);
        total_ticks = (total_ticks + longint'(dt)) &
                      ((longint'(1) <<< msw_pkg::TOTAL_W) - 1);
        win_ticks  = sat_add(win_ticks, longint'(dt), msw_pkg::WIN_W);
        win_angle  = sat_add(win_angle, longint'(ang), msw_pkg::ANG_W);

        if (ch < msw_pkg::NUM_CH &&
            chan_count[ch] < ((longint'(1) <<< msw_pkg::COUNT_WIDTH) - 1)) begin
            sample = (ch < 2) ? longint'({16'b0, sv}) : longint'(sv);
            chan_sum[ch] = sat_add(chan_sum[ch], sample, msw_pkg::SUM_WIDTH);
            chan_count[ch]++;
        end

        if (mode == 0) begin
            angle_out = win_angle;
        end else begin
            if (win_ticks <= WINDOW_TICKS[mode]) return 1'b0;
            t         = longint'(win_ticks);
            mag_angle = (win_angle < 0) ? -win_angle : win_angle;
            q         = longint'(mag_angle) / t;
            r         = longint'(mag_angle) % t;
            rate      = q * 32768 + (r * 32768) / t;
            if (win_angle < 0) begin
                if (rate > (64'd1 << 55)) rate = 64'd1 << 55;
                angle_out = -longint'(rate);
            end else begin
                if (rate > (64'd1 << 55) - 1) rate = (64'd1 << 55) - 1;
                angle_out = longint'(rate);
            end
        end

        res.elapsed = total_ticks[msw_pkg::TOTAL_W-1:0];
        res.angle   = angle_out[msw_pkg::ANG_W-1:0];
        for (int i = 0; i < msw_pkg::NUM_CH; i++) begin
            if (chan_count[i] != 0) begin
                res.mask[i] = 1'b1;
                mag = (chan_sum[i] < 0) ? longint'(-chan_sum[i]) : longint'(chan_sum[i]);
                mag = mag / chan_count[i];
                res.avg[i] = (chan_sum[i] < 0) ? 16'(-longint'(mag)) : 16'(mag);
                if (i < 2) held_temp[i] = res.avg[i];
            end
            if (i < 2) res.avg[i] = held_temp[i];
        end
        clear_window_sums();
        return 1'b1;
    endfunction

    // Drives one record and waits for the block to take it.
    task automatic send_record(input logic signed [31:0] ang, input logic [15:0] cw,
                               input logic signed [15:0] sv, input logic signed [15:0] dt);
        t_window_result res;
        int             gap;
        i_valid           <= 1'b1;
        i_angle_increment <= ang;
        i_channel_word    <= cw;
        i_sample_value    <= sv;
        i_time_increment  <= dt;
        do @(posedge i_clk); while (o_stall);
        records_sent++;
        if (accumulate_record(ang, cw, sv, dt, res)) pending_windows.push_back(res);
        if (pacing_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap        = $urandom_range(1, 8);
                burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 15);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Lowers valid and lets every expected window drain out of the block.
    task automatic drain_block();
        i_valid <= 1'b0;
        wait (pending_windows.size() == 0);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [2:0] p);
        drain_block();
        i_cfg_valid        <= 1'b1;
        i_averaging_period <= p;
        do @(posedge i_clk); while (!o_cfg_ready);
        period_reg = p;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Output side: each result is checked against the oldest expected window.
    task automatic check_field(input string fname, input longint expv, input longint actv);
        if (expv != actv) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, expv, actv);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_window_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            windows_seen++;
            if (pending_windows.size() == 0) begin
                $display("%0t ns: result arrived with none expected, elapsed %0d",
                         $time, o_elapsed_ticks);
                error_count++;
            end else begin
                exp_res = pending_windows.pop_front();
                check_field("elapsed_ticks", exp_res.elapsed, o_elapsed_ticks);
                check_field("angle_value", exp_res.angle, o_angle_value);
                check_field("avg_temp_one", exp_res.avg[0], o_avg_temp_one);
                check_field("avg_temp_two", exp_res.avg[1], o_avg_temp_two);
                check_field("avg_current_one", $signed(exp_res.avg[2]), o_avg_current_one);
                check_field("avg_current_two", $signed(exp_res.avg[3]), o_avg_current_two);
                check_field("avg_voltage", $signed(exp_res.avg[4]), o_avg_voltage);
                check_field("avg_amplitude", $signed(exp_res.avg[5]), o_avg_amplitude);
                check_field("present_mask", exp_res.mask, o_present_mask);
            end
        end
    end

    // Receiver stall pattern, with an occasional long hold-off that lets the block back up.
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= LONG_HOLD;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            case (stall_style)
                1: begin
                    i_stall <= ($urandom_range(0, 9) < 3);
                end
                2: begin
                    i_stall <= (stall_phase % 7) < 2;
                end
                default: begin
                    i_stall <= 1'b0;
                end
            endcase
        end
    end

    // Watchdog: a long run of cycles in which nothing moves means the block has hung.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Per-record mode: field extremes, every channel and unknown channel codes.
    task automatic test_record_extremes();
        write_period(msw_pkg::MODE_RECORD);
        send_record(32'sh7FFFFFFF, 16'h0000, 16'hFFFF, 16'sh7FFF);
        send_record(-32'sh80000000, 16'h0001, 16'h0000, -16'sh8000);
        send_record(32'sd0, 16'h0002, 16'sh7FFF, 16'sd1);
        send_record(32'sd1, 16'h0003, -16'sh8000, 16'sd0);
        send_record(-32'sd1, 16'h0004, 16'shFFFF, -16'sd1);
        send_record(32'sd12345, 16'h0005, 16'sh1234, 16'sd100);
        // Codes above five add no sample; high bits above the channel select are ignored.
        send_record(32'sd7, 16'h0006, 16'sh5555, 16'sd3);
        send_record(32'sd9, 16'h007F, 16'shAAAA, 16'sd3);
        send_record(32'sd11, 16'hFF80, 16'sh0042, 16'sd3);
        send_record(32'sd13, 16'hFFFF, 16'sh0042, 16'sd3);
        send_record(32'sd15, 16'hFF81, 16'sh8001, 16'sd3);
    endtask

    // Windowed modes: negative window time holds the window open, and codes five to
    // seven behave as the longest window.
    task automatic test_windowed_cases();
        write_period(3'd1);
        send_record(32'sd500, 16'h0002, -16'sd7, -16'sd2000);
        send_record(-32'sd900, 16'h0000, 16'sd300, 16'sd4000);
        send_record(32'sd50, 16'h0003, 16'sd9, 16'sd1000);
        send_record(-32'sh80000000, 16'h0004, -16'sd3, 16'sh7FFF);
        send_record(32'sh7FFFFFFF, 16'h0005, 16'sd3, 16'sh7FFF);
        for (int p = 5; p <= 7; p++) begin
            write_period(3'(p));
            repeat (3) send_record($urandom, 16'(p - 5), 16'($urandom), 16'sh7FFF);
        end
    endtask

    // Back-pressure: the receiver holds off while records keep coming.
    task automatic test_output_backpressure();
        write_period(msw_pkg::MODE_RECORD);
        hold_requests++;
        for (int i = 0; i < 12; i++) begin
            send_record($urandom, 16'(i % 7), 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic random_phase(input logic [2:0] p, input int count, input int dt_hi);
        logic [15:0] cw;
        logic [15:0] dt;
        int          pick;
        write_period(p);
        stall_style = $urandom_range(0, 2);
        pacing_on   = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) cw = {9'($urandom), 7'($urandom_range(0, msw_pkg::NUM_CH - 1))};
            else          cw = 16'($urandom);
            dt = ($urandom_range(0, 19) < 17) ? 16'($urandom_range(0, dt_hi)) : 16'($urandom);
            send_record($urandom, cw, 16'($urandom), dt);
        end
    endtask

    task automatic test_random_windows();
        random_phase(3'd0, 20, 32767);
        random_phase(3'd1, 30, 4000);
        random_phase(3'd2, 20, 32767);
        random_phase(3'd3, 30, 32767);
        random_phase(3'd0, 10, 32767);
        random_phase(3'd4, 230, 32767);
        random_phase(3'd2, 20, 32767);
    endtask

    initial begin
        total_ticks = 0;
        period_reg  = msw_pkg::MODE_RECORD;
        held_temp   = '{16'h0, 16'h0};
        clear_window_sums();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_record_extremes();
        test_windowed_cases();
        test_output_backpressure();
        test_random_windows();

        drain_block();
        $display("Sent %0d records across every period code; %0d windows checked.",
                 records_sent, windows_seen);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/msw_pkg.sv
rtl/core/msw_ctrl.sv
rtl/core/msw_dp.sv
rtl/core/multiplexed_sensor_window_averager.sv
verif/tb_multiplexed_sensor_window_averager.sv
